// ===== rtl/tbe_pkg.sv =====
// Package for the threshold bitmap encoder.
// Holds the queue entry type, queue sizing and the count limit; no dependencies.
package tbe_pkg;

  localparam int unsigned GROUP_SIZE    = 16;
  localparam int unsigned HEADER_WORDS  = 4;
  localparam int unsigned MAX_ELEMENTS  = 1048576;
  localparam int unsigned CNT_FIELD_MAX = 2097151;
  localparam logic [20:0] CNT_LIMIT     =
    21'((MAX_ELEMENTS > CNT_FIELD_MAX) ? CNT_FIELD_MAX : MAX_ELEMENTS);
  localparam logic [30:0] THR_RESET     = 31'd65536;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic signed [31:0] residual;
    logic               flag;
    logic               sign;
    logic               counted;
    logic               last;
  } cls_t;

endpackage

// ===== rtl/threshold_bitmap_encoder.sv =====
// Threshold bitmap encoder: one Q16.16 element in per beat, one result beat out per element.
// The front end classifies the element combinationally and writes it into a four-entry queue;
// the back end then moves it into the output register whenever the output is not stalled.
// Throughput is one beat per cycle while neither in_stall nor out_stall holds the flow.
// Reset sets the threshold to 1.0 and clears the queue, the group state and the count.
module threshold_bitmap_encoder import tbe_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [30:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_value,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_residual,
  output logic [31:0]        out_packed_word,
  output logic               out_word_ready,
  output logic [16:0]        out_word_index,
  output logic [20:0]        out_flagged_count,
  output logic               out_end_of_array
);

  cls_t cls;
  cls_t ent;
  logic full;
  logic empty;
  logic pop;

  assign in_stall = full;

  tbe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_value  (in_value),
    .in_last   (in_last),
    .cls       (cls)
  );

  tbe_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_valid),
    .din   (cls),
    .full  (full),
    .pop   (pop),
    .dout  (ent),
    .empty (empty)
  );

  tbe_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .ent               (ent),
    .ent_avail         (!empty),
    .ent_pop           (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_residual      (out_residual),
    .out_packed_word   (out_packed_word),
    .out_word_ready    (out_word_ready),
    .out_word_index    (out_word_index),
    .out_flagged_count (out_flagged_count),
    .out_end_of_array  (out_end_of_array)
  );

endmodule

// ===== rtl/tbe_front.sv =====
// Front end of the threshold bitmap encoder: threshold register and classification.
// Uses tbe_pkg for the classified entry type.
module tbe_front import tbe_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [30:0]        cfg_wdata,
  input  logic signed [31:0] in_value,
  input  logic               in_last,
  output cls_t               cls
);

  logic [30:0]        thr_r;
  logic [30:0]        thr_nxt;
  logic               neg;
  logic [32:0]        mag;
  logic               big;
  logic               half;
  logic signed [32:0] addend;
  logic signed [32:0] res33;

  always_comb begin
    thr_nxt = cfg_we ? cfg_wdata : thr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else begin
      thr_r <= thr_nxt;
    end
  end

  always_comb begin
    neg  = in_value[31];
    mag  = neg ? (33'd0 - {1'b1, in_value}) : {1'b0, in_value};
    big  = mag >= {2'b00, thr_r};
    half = {mag, 1'b0} >= {3'b000, thr_r};
    if (big) begin
      addend = neg ? $signed({2'b00, thr_r}) : -$signed({2'b00, thr_r});
    end else if (neg && half) begin
      addend = $signed({3'b000, thr_r[30:1]});
    end else begin
      addend = 33'sd0;
    end
    res33 = $signed({in_value[31], in_value}) + addend;
    if (res33 > 33'sh0_7FFF_FFFF) begin
      cls.residual = 32'sh7FFF_FFFF;
    end else if (res33 < -33'sh0_8000_0000) begin
      cls.residual = -32'sh8000_0000;
    end else begin
      cls.residual = res33[31:0];
    end
    cls.flag    = big;
    cls.sign    = neg && (big || half);
    cls.counted = big || (neg && half);
    cls.last    = in_last;
  end

endmodule

// ===== rtl/tbe_fifo.sv =====
// Short queue between the front and back ends of the threshold bitmap encoder.
// Uses tbe_pkg for the entry type and depth.
module tbe_fifo import tbe_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cls_t din,
  output logic full,
  input  logic pop,
  output cls_t dout,
  output logic empty
);

  cls_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr_r, wptr_nxt;
  logic [FIFO_AW-1:0] rptr_r, rptr_nxt;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full  = cnt_r == (FIFO_AW+1)'(FIFO_DEPTH);
  assign empty = cnt_r == '0;
  assign dout  = mem_r[rptr_r];

  always_comb begin
    do_push  = push && !full;
    do_pop   = pop && !empty;
    wptr_nxt = do_push ? FIFO_AW'(wptr_r + 1'b1) : wptr_r;
    rptr_nxt = do_pop ? FIFO_AW'(rptr_r + 1'b1) : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = (FIFO_AW+1)'(cnt_r + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = (FIFO_AW+1)'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/tbe_back.sv =====
// Back end of the threshold bitmap encoder: group packing, counting and output register.
// Uses tbe_pkg for the entry type and the count limit.
module tbe_back import tbe_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cls_t               ent,
  input  logic               ent_avail,
  output logic               ent_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_residual,
  output logic [31:0]        out_packed_word,
  output logic               out_word_ready,
  output logic [16:0]        out_word_index,
  output logic [20:0]        out_flagged_count,
  output logic               out_end_of_array
);

  logic [31:0] part_r, part_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [15:0] grp_r, grp_nxt;
  logic [20:0] tot_r, tot_nxt;
  logic        vld_r, vld_nxt;

  logic signed [31:0] res_r;
  logic [31:0]        word_r;
  logic               rdy_r;
  logic [16:0]        idx_r;
  logic [20:0]        cnt_r;
  logic               eoa_r;

  logic [31:0] word;
  logic        ready;
  logic [20:0] tot_upd;

  assign ent_pop = ent_avail && (!vld_r || !out_stall);

  always_comb begin
    word = part_r;
    if (ent.flag) begin
      word[pos_r] = 1'b1;
    end
    if (ent.sign) begin
      word[{1'b1, pos_r}] = 1'b1;
    end
    ready   = ent.last || (pos_r == 4'(GROUP_SIZE - 1));
    tot_upd = (ent.counted && (tot_r < CNT_LIMIT)) ? 21'(tot_r + 1'b1) : tot_r;

    part_nxt = part_r;
    pos_nxt  = pos_r;
    grp_nxt  = grp_r;
    tot_nxt  = tot_r;
    vld_nxt  = vld_r && out_stall;
    if (ent_pop) begin
      vld_nxt = 1'b1;
      if (ent.last) begin
        part_nxt = '0;
        pos_nxt  = '0;
        grp_nxt  = '0;
        tot_nxt  = '0;
      end else if (ready) begin
        part_nxt = '0;
        pos_nxt  = '0;
        grp_nxt  = 16'(grp_r + 1'b1);
        tot_nxt  = tot_upd;
      end else begin
        part_nxt = word;
        pos_nxt  = 4'(pos_r + 1'b1);
        tot_nxt  = tot_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_r <= '0;
      pos_r  <= '0;
      grp_r  <= '0;
      tot_r  <= '0;
      vld_r  <= 1'b0;
    end else begin
      part_r <= part_nxt;
      pos_r  <= pos_nxt;
      grp_r  <= grp_nxt;
      tot_r  <= tot_nxt;
      vld_r  <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ent_pop) begin
      res_r  <= ent.residual;
      word_r <= ready ? word : 32'd0;
      rdy_r  <= ready;
      idx_r  <= 17'({1'b0, grp_r} + 17'(HEADER_WORDS));
      cnt_r  <= tot_upd;
      eoa_r  <= ent.last;
    end
  end

  assign out_valid         = vld_r;
  assign out_residual      = res_r;
  assign out_packed_word   = word_r;
  assign out_word_ready    = rdy_r;
  assign out_word_index    = idx_r;
  assign out_flagged_count = cnt_r;
  assign out_end_of_array  = eoa_r;

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for threshold_bitmap_encoder: directed and random element streams
// are checked beat by beat against a built-in encoder prediction. Depends on tbe_pkg and
// the threshold_bitmap_encoder RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tbe_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          LONG_LEN    = 120;
  localparam longint      RES_MAX     = 64'sh7FFFFFFF;
  localparam longint      RES_MIN     = -64'sh80000000;

  typedef struct {
    logic signed [31:0] residual;
    logic [31:0]        packed_word;
    logic               word_ready;
    logic [16:0]        word_index;
    logic [20:0]        flagged_count;
    logic               end_of_array;
  } enc_result_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [30:0]        cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] in_value;
  logic               in_last;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_residual;
  logic [31:0]        out_packed_word;
  logic               out_word_ready;
  logic [16:0]        out_word_index;
  logic [20:0]        out_flagged_count;
  logic               out_end_of_array;

  enc_result_t pending_results[$];
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  int          src_gap_max = 0;
  int          snk_gap_max = 0;
  int          stall_left = 0;
  int          long_hold = 0;

  logic [30:0] enc_thr;
  logic [31:0] enc_bits;
  logic [3:0]  enc_slot;
  logic [15:0] enc_group;
  logic [20:0] enc_total;

  threshold_bitmap_encoder dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_value          (in_value),
    .in_last           (in_last),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_residual      (out_residual),
    .out_packed_word   (out_packed_word),
    .out_word_ready    (out_word_ready),
    .out_word_index    (out_word_index),
    .out_flagged_count (out_flagged_count),
    .out_end_of_array  (out_end_of_array)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic enc_result_t predict_encode(logic signed [31:0] value, logic last);
    enc_result_t r;
    longint v;
    longint t;
    longint m;
    longint res;
    logic counted;
    v = value;
    t = {33'd0, enc_thr};
    m = (v < 0) ? -v : v;
    res = v;
    counted = 1'b0;
    if (m >= t) begin
      enc_bits[{1'b0, enc_slot}] = 1'b1;
      counted = 1'b1;
      if (v < 0) begin
        enc_bits[{1'b1, enc_slot}] = 1'b1;
        res = v + t;
      end else begin
        res = v - t;
      end
    end else if (v < 0 && 2 * m >= t) begin
      enc_bits[{1'b1, enc_slot}] = 1'b1;
      res = v + (t >> 1);
      counted = 1'b1;
    end
    if (res > RES_MAX) res = RES_MAX;
    if (res < RES_MIN) res = RES_MIN;
    if (counted && enc_total < CNT_LIMIT) enc_total = enc_total + 21'd1;
    r.residual      = res[31:0];
    r.word_ready    = last || (enc_slot == 4'(GROUP_SIZE - 1));
    r.packed_word   = r.word_ready ? enc_bits : 32'd0;
    r.word_index    = {1'b0, enc_group} + 17'(HEADER_WORDS);
    r.flagged_count = enc_total;
    r.end_of_array  = last;
    if (last) begin
      enc_bits  = '0;
      enc_slot  = '0;
      enc_group = '0;
      enc_total = '0;
    end else if (r.word_ready) begin
      enc_bits  = '0;
      enc_slot  = '0;
      enc_group = enc_group + 16'd1;
    end else begin
      enc_slot = enc_slot + 4'd1;
    end
    return r;
  endfunction

  function automatic logic [31:0] pick_value();
    longint t;
    longint v;
    t = {33'd0, enc_thr};
    case ($urandom_range(0, 7))
      0, 1: v = $urandom;
      2, 3: begin
        v = t + longint'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 1)) v = -v;
      end
      4: v = -((t + 1) >> 1) + longint'($urandom_range(0, 2)) - 1;
      5: v = longint'($urandom_range(0, 64)) - 32;
      6: begin
        case ($urandom_range(0, 4))
          0: v = RES_MIN;
          1: v = RES_MAX;
          2: v = 0;
          3: v = -1;
          default: v = 1;
        endcase
      end
      default: begin
        v = (t == 0) ? 0 : longint'($urandom) % t;
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v[31:0];
  endfunction

  function automatic logic [30:0] pick_threshold();
    case ($urandom_range(0, 6))
      0: return 31'd0;
      1: return 31'h7FFFFFFF;
      2: return 31'($urandom_range(1, 300));
      3: return THR_RESET;
      4, 5: return 31'($urandom);
      default: return 31'($urandom) >> $urandom_range(0, 30);
    endcase
  endfunction

  function automatic int pick_gap_max();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 3;
      default: return 16;
    endcase
  endfunction

  function void check_field(string name, logic [31:0] expv, logic [31:0] actv);
    if (actv !== expv) begin
      err_count++;
      $error("%s: expected %0h, got %0h", name, expv, actv);
    end
  endfunction

  task automatic send_element(logic [31:0] value, logic last);
    int gap;
    gap = (src_gap_max == 0) ? 0 : $urandom_range(0, src_gap_max);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_value <= value;
    in_last  <= last;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_results.push_back(predict_encode(value, last));
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_threshold(logic [30:0] thr);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= thr;
    @(negedge clk);
    cfg_we    <= 1'b0;
    enc_thr = thr;
  endtask

  task automatic test_reset_threshold();
    send_element(32'd0, 1'b0);
    send_element(32'd65536, 1'b0);
    send_element(-32'sd65536, 1'b0);
    send_element(-32'sd32768, 1'b0);
    send_element(-32'sd32767, 1'b0);
    send_element(32'd32767, 1'b0);
    send_element(32'h7FFFFFFF, 1'b0);
    send_element(32'h80000000, 1'b0);
    send_element(32'hFFFFFFFF, 1'b1);
    drain();
  endtask

  task automatic test_threshold_extremes();
    write_threshold(31'h7FFFFFFF);
    send_element(32'h80000000, 1'b0);
    send_element(32'h7FFFFFFF, 1'b0);
    send_element(32'hC0000000, 1'b0);
    send_element(32'hC0000001, 1'b1);
    drain();
    write_threshold(31'd0);
    send_element(32'd0, 1'b0);
    send_element(32'd5, 1'b0);
    send_element(-32'sd5, 1'b0);
    send_element(32'h80000000, 1'b1);
    drain();
    write_threshold(31'd3);
    send_element(-32'sd2, 1'b0);
    send_element(-32'sd1, 1'b0);
    send_element(32'd3, 1'b1);
    drain();
  endtask

  task automatic test_random_arrays(int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 3) == 0) begin
        drain();
        write_threshold(pick_threshold());
      end
      src_gap_max = pick_gap_max();
      snk_gap_max = pick_gap_max();
      case ($urandom_range(0, 5))
        0: len = 1;
        1: len = GROUP_SIZE;
        2: len = 2 * GROUP_SIZE;
        default: len = $urandom_range(2, 40);
      endcase
      for (int i = 0; i < len; i++) send_element(pick_value(), i == len - 1);
      sent += len;
    end
    drain();
  endtask

  task automatic test_backpressure();
    write_threshold(pick_threshold());
    src_gap_max = 0;
    snk_gap_max = 0;
    @(posedge clk);
    long_hold = 200;
    for (int i = 0; i < 48; i++) send_element(pick_value(), i == 47);
    drain();
  endtask

  task automatic test_long_array();
    write_threshold(31'd0);
    src_gap_max = 0;
    snk_gap_max = 0;
    for (int i = 0; i < LONG_LEN; i++) send_element($urandom, i == LONG_LEN - 1);
    drain();
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_value  = '0;
    in_last   = 1'b0;
    out_stall = 1'b0;
    enc_thr   = THR_RESET;
    enc_bits  = '0;
    enc_slot  = '0;
    enc_group = '0;
    enc_total = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_threshold();
    test_threshold_extremes();
    test_random_arrays(1400);
    test_backpressure();
    test_long_array();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // The receiver draws a stall length after every result beat; a long hold-off overrides it.
  initial begin
    forever begin
      @(negedge clk);
      if (long_hold > 0) begin
        out_stall <= 1'b1;
        long_hold--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    enc_result_t exp_r;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      stall_left = (snk_gap_max == 0) ? 0 : $urandom_range(0, snk_gap_max);
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= 100) $error("result beat arrived with no element outstanding");
      end else begin
        exp_r = pending_results.pop_front();
        check_field("residual", exp_r.residual, out_residual);
        check_field("packed_word", exp_r.packed_word, out_packed_word);
        check_field("word_ready", {31'd0, exp_r.word_ready}, {31'd0, out_word_ready});
        check_field("word_index", {15'd0, exp_r.word_index}, {15'd0, out_word_index});
        check_field("flagged_count", {11'd0, exp_r.flagged_count}, {11'd0, out_flagged_count});
        check_field("end_of_array", {31'd0, exp_r.end_of_array}, {31'd0, out_end_of_array});
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule

// ===== files.f =====
rtl/tbe_pkg.sv
rtl/tbe_front.sv
rtl/tbe_fifo.sv
rtl/tbe_back.sv
rtl/threshold_bitmap_encoder.sv
bench/testbench.sv
